// ----- sv/cht_pkg.sv -----
`default_nettype none

package cht_pkg;

    // Item field widths
    localparam int KEY_W        = 31;
    localparam int BUCKET_OUT_W = 4;
    localparam int STATUS_W     = 2;

    // Bucket hashing: key is consumed MSB first, HASH_BITS bits per cycle
    localparam int HASH_BITS    = 4;
    localparam int HASH_STEPS   = 8;
    localparam int HASH_W       = HASH_BITS * HASH_STEPS;
    localparam int HASH_CNT_W   = $clog2(HASH_STEPS + 1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_HEAD,
        BK_NODE,
        BK_RESP
    } t_back_state;

endpackage

`default_nettype wire

// ----- sv/cht_if.sv -----
`default_nettype none

interface cht_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [cht_pkg::KEY_W-1:0]  key;

    modport source (output valid, op, key, input ready);
    modport sink   (input valid, op, key, output ready);
endinterface

interface cht_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [cht_pkg::BUCKET_OUT_W-1:0]  bucket;
    logic [cht_pkg::STATUS_W-1:0]      status;

    modport source (output valid, bucket, status, input ready);
    modport sink   (input valid, bucket, status, output ready);
endinterface

`default_nettype wire

// ----- sv/cht_front.sv -----
`default_nettype none

module cht_front #(
    parameter int BUCKETS = 10,
    parameter int BW      = $clog2(BUCKETS),
    parameter int JOB_W   = 1 + cht_pkg::KEY_W + BW
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    cht_req_if.sink           i_req,
    output logic              o_push_valid,
    output logic [JOB_W-1:0]  o_push_data,
    input  wire               i_push_ready
);

    logic                              r_busy;
    logic [cht_pkg::HASH_CNT_W-1:0]    r_cnt;
    logic [cht_pkg::HASH_W-1:0]        r_shift;
    logic [BW-1:0]                     r_rem;
    cht_pkg::t_op                      r_op;
    logic [cht_pkg::KEY_W-1:0]         r_key;
    logic [BW-1:0]                     n_rem;
    logic                              hashing;

    assign i_req.ready  = i_rst_n && !r_busy;
    assign hashing      = r_busy && (r_cnt != cht_pkg::HASH_CNT_W'(cht_pkg::HASH_STEPS));
    assign o_push_valid = r_busy && !hashing;
    assign o_push_data  = {r_op, r_key, r_rem};

    // Restoring remainder, HASH_BITS key bits per cycle
    always_comb begin : p_hash
        logic [BW:0] v;
        v = {1'b0, r_rem};
        for (int i = 0; i < cht_pkg::HASH_BITS; i++) begin
            v = {v[BW-1:0], r_shift[cht_pkg::HASH_W-1-i]};
            if (v >= (BW+1)'(BUCKETS)) begin
                v = v - (BW+1)'(BUCKETS);
            end
        end
        n_rem = v[BW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (!r_busy) begin
            if (i_req.valid) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_rem   <= '0;
                r_shift <= cht_pkg::HASH_W'(i_req.key);
                r_key   <= i_req.key;
                r_op    <= cht_pkg::t_op'(i_req.op);
            end
        end else if (hashing) begin
            r_cnt   <= r_cnt + cht_pkg::HASH_CNT_W'(1);
            r_rem   <= n_rem;
            r_shift <= r_shift << cht_pkg::HASH_BITS;
        end else if (i_push_ready) begin
            r_busy <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cht_queue.sv -----
`default_nettype none

module cht_queue #(
    parameter int W = 8
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_push_valid,
    input  wire  [W-1:0]  i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output logic [W-1:0]  o_pop_data,
    input  wire           i_pop_ready
);

    // Two-entry queue
    logic [W-1:0] r_slot [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         push;
    logic         pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_data   = r_slot[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wp] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- sv/cht_back.sv -----
`default_nettype none

module cht_back #(
    parameter int BUCKETS    = 10,
    parameter int POOL_NODES = 64,
    parameter int BW         = $clog2(BUCKETS),
    parameter int JOB_W      = 1 + cht_pkg::KEY_W + BW
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_pop_valid,
    input  wire  [JOB_W-1:0]  i_pop_data,
    output logic              o_pop_ready,
    cht_rsp_if.source         o_rsp
);

    localparam int IW = $clog2(POOL_NODES);
    localparam int NW = $clog2(POOL_NODES + 1);

    // Memories
    logic [NW-1:0]              r_head_mem [BUCKETS];
    logic [cht_pkg::KEY_W-1:0]  r_key_mem  [POOL_NODES];
    logic [NW-1:0]              r_link_mem [POOL_NODES];
    logic [NW-1:0]              r_head_rd;
    logic [cht_pkg::KEY_W-1:0]  r_nkey;
    logic [NW-1:0]              r_nlink;

    cht_pkg::t_back_state       r_state, n_state;
    logic [BW-1:0]              r_clr, n_clr;
    logic [NW-1:0]              r_used, n_used;
    cht_pkg::t_op               r_op, n_op;
    logic [cht_pkg::KEY_W-1:0]  r_key, n_key;
    logic [BW-1:0]              r_bkt, n_bkt;
    cht_pkg::t_status           r_status, n_status;
    logic                       r_out_valid, n_out_valid;
    logic [cht_pkg::BUCKET_OUT_W-1:0] r_out_bucket, n_out_bucket;
    cht_pkg::t_status           r_out_status, n_out_status;

    logic                       head_we;
    logic [BW-1:0]              head_wa;
    logic [NW-1:0]              head_wd;
    logic [BW-1:0]              head_ra;
    logic                       node_we;
    logic [IW-1:0]              node_ra;

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.bucket = r_out_bucket;
    assign o_rsp.status = r_out_status;

    always_ff @(posedge i_clk) begin
        if (head_we) begin
            r_head_mem[head_wa] <= head_wd;
        end
        r_head_rd <= r_head_mem[head_ra];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_key_mem[r_used[IW-1:0]]  <= r_key;
            r_link_mem[r_used[IW-1:0]] <= r_head_rd;
        end
        r_nkey  <= r_key_mem[node_ra];
        r_nlink <= r_link_mem[node_ra];
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_used       = r_used;
        n_op         = r_op;
        n_key        = r_key;
        n_bkt        = r_bkt;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_bucket = r_out_bucket;
        n_out_status = r_out_status;
        o_pop_ready  = 1'b0;
        head_we      = 1'b0;
        head_wa      = r_bkt;
        head_wd      = r_used;
        head_ra      = i_pop_data[BW-1:0];
        node_we      = 1'b0;
        node_ra      = r_nlink[IW-1:0];

        case (r_state)
            cht_pkg::BK_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                head_wd = NW'(POOL_NODES);
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = cht_pkg::BK_IDLE;
                end else begin
                    n_clr = r_clr + BW'(1);
                end
            end
            cht_pkg::BK_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid) begin
                    n_op    = cht_pkg::t_op'(i_pop_data[JOB_W-1]);
                    n_key   = i_pop_data[JOB_W-2:BW];
                    n_bkt   = i_pop_data[BW-1:0];
                    n_state = cht_pkg::BK_HEAD;
                end
            end
            cht_pkg::BK_HEAD: begin
                node_ra = r_head_rd[IW-1:0];
                n_state = cht_pkg::BK_RESP;
                if (r_op == cht_pkg::OP_INSERT) begin
                    if (r_used >= NW'(POOL_NODES)) begin
                        n_status = cht_pkg::ST_FULL;
                    end else begin
                        node_we  = 1'b1;
                        head_we  = 1'b1;
                        n_used   = r_used + NW'(1);
                        n_status = cht_pkg::ST_INSERTED;
                    end
                end else if (r_head_rd >= r_used) begin
                    n_status = cht_pkg::ST_NOT_FOUND;
                end else begin
                    n_state = cht_pkg::BK_NODE;
                end
            end
            cht_pkg::BK_NODE: begin
                // links always point to older nodes, so the walk ends
                if (r_nkey == r_key) begin
                    n_status = cht_pkg::ST_FOUND;
                    n_state  = cht_pkg::BK_RESP;
                end else if (r_nlink >= r_used) begin
                    n_status = cht_pkg::ST_NOT_FOUND;
                    n_state  = cht_pkg::BK_RESP;
                end
            end
            cht_pkg::BK_RESP: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_bucket = cht_pkg::BUCKET_OUT_W'(r_bkt);
                    n_out_status = r_status;
                    n_state      = cht_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = cht_pkg::BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cht_pkg::BK_CLEAR;
            r_clr       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_bkt        <= n_bkt;
        r_status     <= n_status;
        r_out_bucket <= n_out_bucket;
        r_out_status <= n_out_status;
    end

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NW'(POOL_NODES))
        else $error("pool count beyond pool size");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cht_pkg::BK_HEAD && r_op == cht_pkg::OP_INSERT
            && r_used < NW'(POOL_NODES))
        |=> r_used == NW'($past(r_used) + NW'(1)))
        else $error("insert did not claim exactly one node");

    a_walk_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cht_pkg::BK_NODE)
        |-> ($past(r_state) == cht_pkg::BK_HEAD || $past(r_state) == cht_pkg::BK_NODE))
        else $error("chain walk entered without a head read");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == cht_pkg::BK_RESP)
        else $error("result appeared outside the response step");

endmodule

`default_nettype wire

// ----- sv/chained_hash_table.sv -----
`default_nettype none

// Hash table with separate chaining over a fixed pool of POOL_NODES nodes.
// Each request item is an insert (op 0) or a search (op 1) of a 31-bit key;
// each gives exactly one result item with the bucket (key mod BUCKETS, low 4
// bits) and a status: 0 inserted, 1 found, 2 not found, 3 pool full. Inserts
// link a new node at the head of the bucket's chain; duplicates are kept and
// nodes are never freed. After reset the back end runs a clearing pass over
// the bucket heads; the front end already takes and hashes items meanwhile,
// and they wait in the queue until the pass is done.
// Request ready stays low while reset is asserted.
// The front end hashes the key 4 bits per cycle, then hands the job over and
// takes no new item before that handover; it overlaps the back end's work
// through a two-entry queue. The back end reads the bucket head, then links a
// new node on an insert unless the pool is full, or walks the chain on a
// search, one node-memory read per visited node, and then loads the result.
// A result waits in an output register, so the back end moves on as soon as
// the previous result has left that register.

module chained_hash_table #(
    parameter int BUCKETS    = 10,
    parameter int POOL_NODES = 64
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    cht_req_if.sink   i_req,
    cht_rsp_if.source o_rsp
);

    localparam int BW    = $clog2(BUCKETS);
    localparam int JOB_W = 1 + cht_pkg::KEY_W + BW;

    // Job word between front and back: {op, key, bucket}
    logic              push_valid;
    logic              push_ready;
    logic [JOB_W-1:0]  push_data;
    logic              pop_valid;
    logic              pop_ready;
    logic [JOB_W-1:0]  pop_data;

    // Accept the item, hash the key to its bucket
    cht_front #(
        .BUCKETS (BUCKETS),
        .BW      (BW),
        .JOB_W   (JOB_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (push_valid),
        .o_push_data  (push_data),
        .i_push_ready (push_ready)
    );

    // Hold hashed jobs so the front can keep hashing while a walk runs
    cht_queue #(
        .W (JOB_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_data  (push_data),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_data   (pop_data),
        .i_pop_ready  (pop_ready)
    );

    // Insert into or walk the chain, drive the result register
    cht_back #(
        .BUCKETS    (BUCKETS),
        .POOL_NODES (POOL_NODES),
        .BW         (BW),
        .JOB_W      (JOB_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_data  (pop_data),
        .o_pop_ready (pop_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire
